>>> hdl/pnm_header_and_pixel_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// PNM parser assertion macros
// Concurrent assertion wrappers clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PNM_HEADER_AND_PIXEL_PARSER_UNIT_ASSERT_SVH
`define PNM_HEADER_AND_PIXEL_PARSER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PNM_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pnm parser assertion failed");

`define PNM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pnm parser assertion failed");

`else

`define PNM_ASSERT(lbl, cond)

`define PNM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hdl/pnm_pkg.sv
// ----------------------------------------------------------------------------
// PNM parser package
// Result codes, result record and size status shared by the parser modules.
// ----------------------------------------------------------------------------
package pnm_pkg;

    localparam int OUT_DIM_W = 16;

    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_MAGIC  = 2'd0;
    localparam logic [1:0] ERR_NUMBER = 2'd1;
    localparam logic [1:0] ERR_SIZE   = 2'd2;

    typedef struct packed {
        logic [1:0]           kind;
        logic [7:0]           pixel;
        logic                 last;
        logic [OUT_DIM_W-1:0] width;
        logic [OUT_DIM_W-1:0] height;
        logic [1:0]           channels;
        logic [15:0]          max_sample;
        logic [1:0]           error_code;
    } res_t;

    typedef struct packed {
        logic overflow;
        logic mismatch;
    } size_stat_t;

endpackage

>>> hdl/pnm_header_and_pixel_parser_unit.sv
// ----------------------------------------------------------------------------
// PNM header and pixel parser
// Parses a binary PGM/PPM byte stream into a header record and pixel bytes.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with data_byte and file_start; file_start
// marks the first byte of a file and restarts the parser. Output channel:
// out_valid/out_ready with kind, pixel, last, width, height, channels,
// max_sample and error_code; fields that do not belong to the kind read zero.
// An input byte gives zero or one result item.
// Each byte passes through the input register, and its result is loaded
// into the output register once that register has space, so an output
// stall can hold the byte back in the input register.
// Throughput: one byte per cycle while the output is not stalled; the
// size product is formed in two register stages while maxval is still being
// read, so it never slows the stream.
// Reset: parser idle, no reference size; bytes without file_start are
// dropped with no result.
// Stall: while out_ready is low and a result waits, the input register holds
// one more byte and in_ready drops; no item is lost or repeated.
// ----------------------------------------------------------------------------
module pnm_header_and_pixel_parser_unit
    import pnm_pkg::*;
#(
    parameter int DIM_BITS   = 16,
    parameter int COUNT_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        file_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  pixel,
    output logic        last,
    output logic [15:0] width,
    output logic [15:0] height,
    output logic [1:0]  channels,
    output logic [15:0] max_sample,
    output logic [1:0]  error_code
);

    logic                  item_valid_reg;
    logic [7:0]            data_reg;
    logic                  start_reg;
    logic                  space;
    logic                  advance;
    logic                  res_valid;
    res_t                  res;
    res_t                  res_out;
    logic                  size_load;
    logic                  size_commit;
    logic [DIM_BITS-1:0]   width_val;
    logic [DIM_BITS-1:0]   height_val;
    logic [1:0]            channels_val;
    size_stat_t            size_stat;
    logic [COUNT_BITS-1:0] count;

    assign advance  = item_valid_reg && space;
    assign in_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg  <= data_byte;
            start_reg <= file_start;
        end
    end

    pnm_parse #(
        .DIM_BITS   (DIM_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .data_byte    (data_reg),
        .file_start   (start_reg),
        .size_stat    (size_stat),
        .count        (count),
        .res_valid    (res_valid),
        .res          (res),
        .size_load    (size_load),
        .size_commit  (size_commit),
        .width_val    (width_val),
        .height_val   (height_val),
        .channels_val (channels_val)
    );

    pnm_size #(
        .DIM_BITS   (DIM_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_size (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (size_load),
        .width_val    (width_val),
        .height_val   (height_val),
        .channels_val (channels_val),
        .commit       (size_commit),
        .stat         (size_stat),
        .count        (count)
    );

    pnm_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .res_in    (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .res_out   (res_out),
        .space     (space)
    );

    assign kind       = res_out.kind;
    assign pixel      = res_out.pixel;
    assign last       = res_out.last;
    assign width      = res_out.width;
    assign height     = res_out.height;
    assign channels   = res_out.channels;
    assign max_sample = res_out.max_sample;
    assign error_code = res_out.error_code;

endmodule

>>> hdl/pnm_size.sv
// ----------------------------------------------------------------------------
// PNM image size unit
// Forms channels*width*height over two register stages, checks it against
// the count range and holds the reference size of the first good header.
// ----------------------------------------------------------------------------
module pnm_size
    import pnm_pkg::*;
#(
    parameter int DIM_BITS   = 16,
    parameter int COUNT_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [DIM_BITS-1:0]   width_val,
    input  logic [DIM_BITS-1:0]   height_val,
    input  logic [1:0]            channels_val,
    input  logic                  commit,
    output size_stat_t            stat,
    output logic [COUNT_BITS-1:0] count
);

    localparam int PROD_W = 2 * DIM_BITS;
    localparam int NUM_W  = PROD_W + 2;
    localparam int CMP_W  = (NUM_W > COUNT_BITS) ? NUM_W : COUNT_BITS;

    logic [PROD_W-1:0]     prod_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [NUM_W-1:0]      num_next;
    logic [COUNT_BITS-1:0] ref_reg;
    logic                  ref_valid_reg;

    always_comb
    begin
        num_next = '0;
        if (channels_val[0])
        begin
            num_next = num_next + NUM_W'(prod_reg);
        end
        if (channels_val[1])
        begin
            num_next = num_next + (NUM_W'(prod_reg) << 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= PROD_W'(width_val) * PROD_W'(height_val);
        end
        num_reg <= num_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg       <= '0;
            ref_valid_reg <= 1'b0;
        end
        else if (commit && !ref_valid_reg)
        begin
            ref_reg       <= count;
            ref_valid_reg <= 1'b1;
        end
    end

    assign count         = COUNT_BITS'(num_reg);
    assign stat.overflow = (num_reg >> COUNT_BITS) != '0;
    assign stat.mismatch = ref_valid_reg && (CMP_W'(num_reg) != CMP_W'(ref_reg));

endmodule

>>> hdl/pnm_parse.sv
// ----------------------------------------------------------------------------
// PNM header and pixel parser core
// Byte-wise state machine: magic token, whitespace and comment skipping,
// decimal fields, header report and pixel pass-through.
// ----------------------------------------------------------------------------
`include "pnm_header_and_pixel_parser_unit_assert.svh"

module pnm_parse
    import pnm_pkg::*;
#(
    parameter int DIM_BITS   = 16,
    parameter int COUNT_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            data_byte,
    input  logic                  file_start,
    input  size_stat_t            size_stat,
    input  logic [COUNT_BITS-1:0] count,
    output logic                  res_valid,
    output res_t                  res,
    output logic                  size_load,
    output logic                  size_commit,
    output logic [DIM_BITS-1:0]   width_val,
    output logic [DIM_BITS-1:0]   height_val,
    output logic [1:0]            channels_val
);

    localparam int ACC_W = (DIM_BITS > 16) ? DIM_BITS : 16;
    localparam int MUL_W = ACC_W + 4;

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_MAGIC_WS  = 4'd1;
    localparam logic [3:0] PH_MAGIC_P   = 4'd2;
    localparam logic [3:0] PH_MAGIC_SEP = 4'd3;
    localparam logic [3:0] PH_SKIP_W    = 4'd4;
    localparam logic [3:0] PH_CMT_W     = 4'd5;
    localparam logic [3:0] PH_NUM_W     = 4'd6;
    localparam logic [3:0] PH_SKIP_H    = 4'd7;
    localparam logic [3:0] PH_CMT_H     = 4'd8;
    localparam logic [3:0] PH_NUM_H     = 4'd9;
    localparam logic [3:0] PH_SKIP_M    = 4'd10;
    localparam logic [3:0] PH_CMT_M     = 4'd11;
    localparam logic [3:0] PH_NUM_M     = 4'd12;
    localparam logic [3:0] PH_PIXELS    = 4'd13;

    localparam logic [3:0] OFS_CMT = 4'd1;
    localparam logic [3:0] OFS_NUM = 4'd2;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] CHAN_GREY  = 2'd1;
    localparam logic [1:0] CHAN_COLOR = 2'd3;

    logic [3:0]            phase_reg;
    logic [3:0]            phase_next;
    logic [ACC_W-1:0]      acc_reg;
    logic [ACC_W-1:0]      acc_next;
    logic [DIM_BITS-1:0]   held_width_reg;
    logic [DIM_BITS-1:0]   held_width_next;
    logic [DIM_BITS-1:0]   held_height_reg;
    logic [DIM_BITS-1:0]   held_height_next;
    logic [1:0]            held_channels_reg;
    logic [1:0]            held_channels_next;
    logic [COUNT_BITS-1:0] remain_reg;
    logic [COUNT_BITS-1:0] remain_next;

    logic [3:0]            phase_cur;
    logic                  is_ws;
    logic                  is_digit;
    logic [MUL_W-1:0]      acc_mul;
    logic                  over_dim;
    logic                  over_max;
    logic                  err;
    logic [1:0]            err_code;
    logic                  pixel_out;

    assign phase_cur = file_start ? PH_MAGIC_WS : phase_reg;
    assign is_ws     = (data_byte == CH_SPACE) ||
                       ((data_byte >= CH_TAB) && (data_byte <= CH_CR));
    assign is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign acc_mul   = (MUL_W'(acc_reg) << 3) + (MUL_W'(acc_reg) << 1) +
                       MUL_W'(data_byte[3:0]);
    assign over_dim  = (acc_mul >> DIM_BITS) != '0;
    assign over_max  = (acc_mul >> 16) != '0;

    always_comb
    begin
        phase_next         = step ? phase_cur : phase_reg;
        acc_next           = acc_reg;
        held_width_next    = held_width_reg;
        held_height_next   = held_height_reg;
        held_channels_next = held_channels_reg;
        remain_next        = remain_reg;
        res_valid          = 1'b0;
        res                = '0;
        size_load          = 1'b0;
        size_commit        = 1'b0;
        err                = 1'b0;
        err_code           = ERR_MAGIC;

        if (step)
        begin
            case (phase_cur)
                PH_IDLE:
                begin
                end
                PH_MAGIC_WS:
                begin
                    if (data_byte == CH_P)
                    begin
                        phase_next = PH_MAGIC_P;
                    end
                    else if (!is_ws)
                    begin
                        err = 1'b1;
                    end
                end
                PH_MAGIC_P:
                begin
                    if (data_byte == CH_5 || data_byte == CH_6)
                    begin
                        held_channels_next = (data_byte == CH_5) ? CHAN_GREY : CHAN_COLOR;
                        phase_next         = PH_MAGIC_SEP;
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
                PH_MAGIC_SEP:
                begin
                    if (is_ws)
                    begin
                        phase_next = PH_SKIP_W;
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
                PH_SKIP_W, PH_SKIP_H, PH_SKIP_M:
                begin
                    if (data_byte == CH_HASH)
                    begin
                        phase_next = phase_cur + OFS_CMT;
                    end
                    else if (is_digit)
                    begin
                        acc_next   = ACC_W'(data_byte[3:0]);
                        phase_next = phase_cur + OFS_NUM;
                    end
                    else if (!is_ws)
                    begin
                        err      = 1'b1;
                        err_code = ERR_NUMBER;
                    end
                end
                PH_CMT_W, PH_CMT_H, PH_CMT_M:
                begin
                    if (data_byte == CH_LF)
                    begin
                        phase_next = phase_cur - OFS_CMT;
                    end
                end
                PH_NUM_W, PH_NUM_H:
                begin
                    if (is_digit)
                    begin
                        if (over_dim)
                        begin
                            err      = 1'b1;
                            err_code = ERR_NUMBER;
                        end
                        else
                        begin
                            acc_next = ACC_W'(acc_mul);
                        end
                    end
                    else
                    begin
                        if (phase_cur == PH_NUM_W)
                        begin
                            held_width_next = DIM_BITS'(acc_reg);
                        end
                        else
                        begin
                            held_height_next = DIM_BITS'(acc_reg);
                            size_load        = 1'b1;
                        end
                        if (is_ws)
                        begin
                            phase_next = phase_cur + OFS_CMT;
                        end
                        else if (data_byte == CH_HASH)
                        begin
                            phase_next = phase_cur + OFS_NUM;
                        end
                        else
                        begin
                            err      = 1'b1;
                            err_code = ERR_NUMBER;
                        end
                    end
                end
                PH_NUM_M:
                begin
                    if (is_digit)
                    begin
                        if (over_max)
                        begin
                            err      = 1'b1;
                            err_code = ERR_NUMBER;
                        end
                        else
                        begin
                            acc_next = ACC_W'(acc_mul);
                        end
                    end
                    else if (!is_ws || size_stat.overflow)
                    begin
                        err      = 1'b1;
                        err_code = ERR_NUMBER;
                    end
                    else if (size_stat.mismatch)
                    begin
                        err      = 1'b1;
                        err_code = ERR_SIZE;
                    end
                    else
                    begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_HEADER;
                        res.width      = OUT_DIM_W'(held_width_reg);
                        res.height     = OUT_DIM_W'(held_height_reg);
                        res.channels   = held_channels_reg;
                        res.max_sample = 16'(acc_reg);
                        size_commit    = 1'b1;
                        remain_next    = count;
                        phase_next     = (count != '0) ? PH_PIXELS : PH_IDLE;
                    end
                end
                PH_PIXELS:
                begin
                    remain_next = remain_reg - COUNT_BITS'(1);
                    res_valid   = 1'b1;
                    res.kind    = KIND_PIXEL;
                    res.pixel   = data_byte;
                    if (remain_reg == COUNT_BITS'(1))
                    begin
                        res.last   = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (err)
            begin
                res_valid      = 1'b1;
                res            = '0;
                res.kind       = KIND_ERROR;
                res.error_code = err_code;
                phase_next     = PH_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            acc_reg           <= '0;
            held_width_reg    <= '0;
            held_height_reg   <= '0;
            held_channels_reg <= '0;
            remain_reg        <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            acc_reg           <= acc_next;
            held_width_reg    <= held_width_next;
            held_height_reg   <= held_height_next;
            held_channels_reg <= held_channels_next;
            remain_reg        <= remain_next;
        end
    end

    assign width_val    = held_width_reg;
    assign height_val   = DIM_BITS'(acc_reg);
    assign channels_val = held_channels_reg;

    assign pixel_out = res_valid && (res.kind == KIND_PIXEL);

    `PNM_ASSERT(a_pixel_only_in_pixels, !pixel_out || (phase_reg == PH_PIXELS && !file_start))
    `PNM_ASSERT_NEXT(a_last_goes_idle, step && res_valid && res.last, phase_reg == PH_IDLE)
    `PNM_ASSERT_NEXT(a_error_goes_idle, res_valid && res.kind == KIND_ERROR, phase_reg == PH_IDLE)

endmodule

>>> hdl/pnm_out_buf.sv
// ----------------------------------------------------------------------------
// PNM parser output register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module pnm_out_buf
    import pnm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  res_t res_in,
    input  logic out_ready,
    output logic out_valid,
    output res_t res_out,
    output logic space
);

    logic out_valid_reg;
    res_t res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign space     = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign res_out   = res_reg;

endmodule

>>> verif/tb_pnm_header_and_pixel_parser_unit.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// PNM header and pixel parser testbench
// Feeds P5/P6 byte streams (good files with random whitespace, comments and
// pixel data, plus broken magic, bad numbers, overflows, size mismatches and
// restarts) through the valid/ready input, predicts every header, pixel and
// error item in a scoreboard and checks them in order at the output, with
// random bursts, gaps and output stalls.
// ----------------------------------------------------------------------------

import pnm_pkg::*;

localparam logic [7:0] CH_P    = 8'h50;
localparam logic [7:0] CH_5    = 8'h35;
localparam logic [7:0] CH_6    = 8'h36;
localparam logic [7:0] CH_HASH = 8'h23;
localparam logic [7:0] CH_LF   = 8'h0A;
localparam logic [7:0] CH_ZERO = 8'h30;
localparam logic [7:0] CH_NINE = 8'h39;

localparam int unsigned FLD_WIDTH  = 0;
localparam int unsigned FLD_HEIGHT = 1;
localparam int unsigned FLD_MAXVAL = 2;

localparam logic [31:0] DIM_MAX    = 32'd65535;
localparam logic [31:0] MAXVAL_MAX = 32'd65535;
localparam logic [63:0] COUNT_MAX  = 64'hFFFF_FFFF;

function automatic bit is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
endfunction

function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
endfunction

class pnm_parse_scoreboard;
    typedef enum {ST_IDLE, ST_LEAD, ST_MAGIC_P, ST_MAGIC_SEP, ST_SKIP, ST_COMMENT,
                  ST_NUMBER, ST_PIXELS} parse_st_t;

    parse_st_t   st;
    int unsigned fld;
    logic [31:0] acc;
    logic [15:0] w_held;
    logic [15:0] h_held;
    logic [1:0]  ch_held;
    logic [31:0] pix_left;
    logic [63:0] ref_size;
    bit          ref_valid;
    res_t        pending_results[$];
    int unsigned mismatches;
    int unsigned bytes_in;
    int unsigned files;
    int unsigned headers;
    int unsigned pixels;
    int unsigned image_ends;
    int unsigned errors[3];

    function new();
        st = ST_IDLE;
        fld = FLD_WIDTH;
        acc = '0;
        w_held = '0;
        h_held = '0;
        ch_held = '0;
        pix_left = '0;
        ref_size = '0;
        ref_valid = 1'b0;
        mismatches = 0;
        bytes_in = 0;
        files = 0;
        headers = 0;
        pixels = 0;
        image_ends = 0;
        errors = '{0, 0, 0};
    endfunction

    function res_t error_item(logic [1:0] code);
        res_t r;
        r = '0;
        r.kind = KIND_ERROR;
        r.error_code = code;
        st = ST_IDLE;
        return r;
    endfunction

    function res_t close_header(logic [15:0] maxv);
        res_t        r;
        logic [63:0] n;
        n = 64'(ch_held) * 64'(w_held) * 64'(h_held);
        if (n > COUNT_MAX)
            return error_item(ERR_NUMBER);
        if (ref_valid && n != ref_size)
            return error_item(ERR_SIZE);
        if (!ref_valid)
        begin
            ref_size = n;
            ref_valid = 1'b1;
        end
        r = '0;
        r.kind = KIND_HEADER;
        r.width = w_held;
        r.height = h_held;
        r.channels = ch_held;
        r.max_sample = maxv;
        pix_left = n[31:0];
        st = (n != 0) ? ST_PIXELS : ST_IDLE;
        return r;
    endfunction

    function void note_byte(logic [7:0] c, logic start);
        res_t r;
        bit   got;
        r = '0;
        got = 1'b0;
        bytes_in++;
        if (start)
        begin
            st = ST_LEAD;
            acc = '0;
            files++;
        end
        case (st)
            ST_IDLE: ;
            ST_LEAD:
                if (c == CH_P)
                    st = ST_MAGIC_P;
                else if (!is_space(c))
                begin
                    r = error_item(ERR_MAGIC);
                    got = 1'b1;
                end
            ST_MAGIC_P:
                if (c == CH_5 || c == CH_6)
                begin
                    ch_held = (c == CH_5) ? 2'd1 : 2'd3;
                    st = ST_MAGIC_SEP;
                end
                else
                begin
                    r = error_item(ERR_MAGIC);
                    got = 1'b1;
                end
            ST_MAGIC_SEP:
                if (is_space(c))
                begin
                    st = ST_SKIP;
                    fld = FLD_WIDTH;
                end
                else
                begin
                    r = error_item(ERR_MAGIC);
                    got = 1'b1;
                end
            ST_SKIP:
                if (c == CH_HASH)
                    st = ST_COMMENT;
                else if (is_digit(c))
                begin
                    acc = c - CH_ZERO;
                    st = ST_NUMBER;
                end
                else if (!is_space(c))
                begin
                    r = error_item(ERR_NUMBER);
                    got = 1'b1;
                end
            ST_COMMENT:
                if (c == CH_LF)
                    st = ST_SKIP;
            ST_NUMBER:
                if (is_digit(c))
                begin
                    acc = acc * 10 + (c - CH_ZERO);
                    if (acc > ((fld == FLD_MAXVAL) ? MAXVAL_MAX : DIM_MAX))
                    begin
                        r = error_item(ERR_NUMBER);
                        got = 1'b1;
                    end
                end
                else if (fld == FLD_MAXVAL)
                begin
                    r = is_space(c) ? close_header(acc[15:0]) : error_item(ERR_NUMBER);
                    got = 1'b1;
                end
                else
                begin
                    if (fld == FLD_WIDTH)
                        w_held = acc[15:0];
                    else
                        h_held = acc[15:0];
                    fld++;
                    if (is_space(c))
                        st = ST_SKIP;
                    else if (c == CH_HASH)
                        st = ST_COMMENT;
                    else
                    begin
                        r = error_item(ERR_NUMBER);
                        got = 1'b1;
                    end
                end
            ST_PIXELS:
            begin
                pix_left = pix_left - 1;
                r.kind = KIND_PIXEL;
                r.pixel = c;
                r.last = (pix_left == 0);
                if (r.last)
                    st = ST_IDLE;
                got = 1'b1;
            end
        endcase
        if (got)
            pending_results.insert(pending_results.size(), r);
    endfunction

    task report(string msg);
        mismatches++;
        if (mismatches <= 100)
            $display("MISMATCH: %s", msg);
    endtask

    task check_result(res_t got);
        res_t want;
        if (pending_results.size() == 0)
        begin
            report($sformatf("result with nothing expected, kind %0d", got.kind));
            return;
        end
        want = pending_results.pop_front();
        if (got.kind !== want.kind)
            report($sformatf("kind got %0d want %0d", got.kind, want.kind));
        if (got.pixel !== want.pixel)
            report($sformatf("pixel got %0h want %0h", got.pixel, want.pixel));
        if (got.last !== want.last)
            report($sformatf("last got %0d want %0d", got.last, want.last));
        if (got.width !== want.width)
            report($sformatf("width got %0d want %0d", got.width, want.width));
        if (got.height !== want.height)
            report($sformatf("height got %0d want %0d", got.height, want.height));
        if (got.channels !== want.channels)
            report($sformatf("channels got %0d want %0d", got.channels, want.channels));
        if (got.max_sample !== want.max_sample)
            report($sformatf("max_sample got %0d want %0d", got.max_sample, want.max_sample));
        if (got.error_code !== want.error_code)
            report($sformatf("error_code got %0d want %0d", got.error_code, want.error_code));
        case (want.kind)
            KIND_PIXEL:
            begin
                pixels++;
                if (want.last)
                    image_ends++;
            end
            KIND_HEADER: headers++;
            default: errors[want.error_code]++;
        endcase
    endtask

    function int unsigned results_due();
        return pending_results.size();
    endfunction
endclass

module tb_pnm_header_and_pixel_parser_unit;
    localparam int unsigned IDLE_LIMIT   = 3000;
    localparam int unsigned TARGET_BYTES = 1650;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned REF_PIXELS   = 12;

    typedef enum {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        file_start = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  pixel;
    logic        last;
    logic [15:0] width;
    logic [15:0] height;
    logic [1:0]  channels;
    logic [15:0] max_sample;
    logic [1:0]  error_code;

    pnm_parse_scoreboard sb = new();
    logic [7:0]          fbytes[$];
    int unsigned         burst_left = 0;
    bit                  rx_hold_req = 1'b0;
    int unsigned         idle_cycles = 0;

    pnm_header_and_pixel_parser_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .file_start (file_start),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .pixel      (pixel),
        .last       (last),
        .width      (width),
        .height     (height),
        .channels   (channels),
        .max_sample (max_sample),
        .error_code (error_code)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin : rx_pattern
        rx_mode_t    mode;
        int unsigned mode_left;
        mode = RX_FREE;
        mode_left = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                rx_hold_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    RX_FREE:   out_ready <= 1'b1;
                    RX_MOSTLY: out_ready <= ($urandom_range(0, 9) < 7);
                    RX_SPARSE: out_ready <= ($urandom_range(0, 9) < 3);
                    default:   out_ready <= (mode_left % 4 != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(res_t'{kind, pixel, last, width, height, channels, max_sample,
                                   error_code});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("tb_pnm_header_and_pixel_parser_unit failed");
            $finish;
        end
    end

    function automatic void add_byte(logic [7:0] b);
        fbytes.insert(fbytes.size(), b);
    endfunction

    function automatic logic [7:0] ws_byte();
        logic [7:0] spaces [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
        return spaces[$urandom_range(0, 5)];
    endfunction

    function automatic logic [7:0] junk_byte(bit allow_hash);
        logic [7:0] c;
        do
            c = 8'($urandom);
        while (is_space(c) || is_digit(c) || (c == CH_HASH && !allow_hash));
        return c;
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic void put_skip();
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0)
        begin
            add_byte(CH_HASH);
            repeat ($urandom_range(0, 6))
            begin
                do
                    c = 8'($urandom);
                while (c == CH_LF);
                add_byte(c);
            end
            add_byte(CH_LF);
        end
        else
            add_byte(ws_byte());
        repeat ($urandom_range(0, 2)) add_byte(ws_byte());
    endfunction

    function automatic void put_num(int unsigned v);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) add_byte(CH_ZERO);
        put_str($sformatf("%0d", v));
    endfunction

    function automatic void put_magic(int unsigned ch);
        if ($urandom_range(0, 3) == 0)
            add_byte(ws_byte());
        add_byte(CH_P);
        add_byte((ch == 3) ? CH_6 : CH_5);
        add_byte(ws_byte());
        if ($urandom_range(0, 1) == 0)
            put_skip();
    endfunction

    function automatic void put_header(int unsigned ch, int unsigned w, int unsigned h,
                                       int unsigned maxv);
        put_magic(ch);
        put_num(w);
        put_skip();
        put_num(h);
        put_skip();
        put_num(maxv);
        add_byte(ws_byte());
    endfunction

    function automatic void put_pixels(int unsigned n);
        repeat (n) add_byte(8'($urandom));
    endfunction

    task automatic send_item(logic [7:0] b, logic s);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        data_byte <= b;
        file_start <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_byte(b, s);
    endtask

    task automatic send_file();
        for (int i = 0; i < fbytes.size(); i++)
            send_item(fbytes[i], i == 0);
        fbytes.delete();
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.results_due() != 0) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [7:0]  px_pattern [8] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80,
                                        8'h7F, 8'hFE};
        int unsigned dims1 [6] = '{1, 2, 3, 4, 6, 12};
        int unsigned dims3 [3] = '{1, 2, 4};
        int unsigned file_no;
        int unsigned pick;
        int unsigned ch;
        int unsigned w;
        int unsigned h;
        int unsigned maxv;
        int unsigned f;
        logic [7:0]  c;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drop: bytes with no file start after reset
        send_item(8'hFF, 1'b0);
        send_item(CH_P, 1'b0);
        send_item(8'h00, 1'b0);

        put_str("P5\n# first\n3 4\n255\n");
        foreach (px_pattern[i])
            add_byte(px_pattern[i]);
        put_pixels(4);
        add_byte(8'h42);
        send_file();
        put_str(" \tP6 2#x\n2 65535\n");
        put_pixels(12);
        send_file();
        put_str("X5\n");
        send_file();
        put_str("P7 ");
        send_file();
        put_str("P5#");
        send_file();
        put_str("P5 1a 12 255 ");
        send_file();
        put_str("P5 -3 4 255 ");
        send_file();
        put_str("P5 3 4 255#");
        send_file();
        put_str("P5 65536 1 255 ");
        send_file();
        put_str("P5 12 1 65536 ");
        send_file();
        put_str("P6 65535 65535 255 ");
        send_file();
        put_str("P5 65535 65535 0 ");
        send_file();
        put_str("P5 0 7 255 ");
        send_file();
        put_str("P5 12 1 1\n");
        put_pixels(5);
        send_file();
        put_str("P6 2 ");
        send_file();
        put_str("P6\v1\f4\n00255 ");
        put_pixels(12);
        send_file();

        file_no = 0;
        while (sb.bytes_in < TARGET_BYTES)
        begin
            file_no++;
            if (file_no % 37 == 0)
                rx_hold_req = 1'b1;
            if (file_no % 23 == 0)
                wait_drained();
            pick = $urandom_range(0, 99);
            ch = ($urandom_range(0, 1) == 0) ? 1 : 3;
            w = (ch == 1) ? dims1[$urandom_range(0, 5)] : dims3[$urandom_range(0, 2)];
            h = REF_PIXELS / ch / w;
            case ($urandom_range(0, 3))
                0: maxv = 255;
                1: maxv = 65535;
                2: maxv = 0;
                default: maxv = $urandom_range(1, 65535);
            endcase
            if (pick < 64)
            begin
                put_header(ch, w, h, maxv);
                put_pixels(REF_PIXELS);
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 8)) void'(fbytes.pop_back());
                else if ($urandom_range(0, 7) == 0)
                    put_pixels($urandom_range(1, 4));
            end
            else if (pick < 72)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        if ($urandom_range(0, 1) == 0)
                            add_byte(ws_byte());
                        do
                            c = 8'($urandom);
                        while (is_space(c) || c == CH_P);
                        add_byte(c);
                    end
                    1:
                    begin
                        add_byte(CH_P);
                        do
                            c = 8'($urandom);
                        while (c == CH_5 || c == CH_6);
                        add_byte(c);
                    end
                    default:
                    begin
                        add_byte(CH_P);
                        add_byte((ch == 3) ? CH_6 : CH_5);
                        do
                            c = 8'($urandom);
                        while (is_space(c));
                        add_byte(c);
                    end
                endcase
                put_pixels($urandom_range(0, 3));
            end
            else if (pick < 80)
            begin
                put_magic(ch);
                f = $urandom_range(FLD_WIDTH, FLD_MAXVAL);
                if (f > FLD_WIDTH)
                begin
                    put_num(w);
                    put_skip();
                end
                if (f > FLD_HEIGHT)
                begin
                    put_num(h);
                    put_skip();
                end
                if ($urandom_range(0, 2) == 0)
                    add_byte(junk_byte(1'b0));
                else
                begin
                    put_num($urandom_range(0, 999));
                    add_byte(junk_byte(f == FLD_MAXVAL));
                end
                put_pixels($urandom_range(0, 3));
            end
            else if (pick < 86)
            begin
                case ($urandom_range(0, 3))
                    0: put_header(ch, $urandom_range(65536, 4000000), h, maxv);
                    1: put_header(ch, w, $urandom_range(65536, 4000000), maxv);
                    2: put_header(ch, w, h, $urandom_range(65536, 4000000));
                    default: put_header(3, $urandom_range(40000, 65535),
                                        $urandom_range(40000, 65535), maxv);
                endcase
                put_pixels($urandom_range(0, 3));
            end
            else if (pick < 93)
            begin
                put_header(ch, $urandom_range(0, 20), $urandom_range(0, 20), maxv);
                put_pixels(4);
            end
            else
            begin
                put_header(ch, w, h, maxv);
                repeat ($urandom_range(1, fbytes.size() - 1)) void'(fbytes.pop_back());
            end
            send_file();
        end

        wait_drained();
        repeat (20) @(posedge clk);
        $display("run covered %0d files: %0d headers, %0d pixel bytes, %0d complete images",
                 sb.files, sb.headers, sb.pixels, sb.image_ends);
        $display("errors seen: %0d bad magic, %0d bad number, %0d size mismatch",
                 sb.errors[ERR_MAGIC], sb.errors[ERR_NUMBER], sb.errors[ERR_SIZE]);
        if (sb.mismatches == 0 && sb.results_due() == 0)
            $display("tb_pnm_header_and_pixel_parser_unit passed");
        else
            $display("tb_pnm_header_and_pixel_parser_unit failed");
        $finish;
    end
endmodule

>>> pnm_header_and_pixel_parser_unit.f
+incdir+hdl
hdl/pnm_pkg.sv
hdl/pnm_size.sv
hdl/pnm_parse.sv
hdl/pnm_out_buf.sv
hdl/pnm_header_and_pixel_parser_unit.sv
verif/tb_pnm_header_and_pixel_parser_unit.sv
